@@ rtl/lcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdc_pkg: shared types and codes for the lamp click and dimmer control
// Holds the register indexes, click event codes, color mode codes and the
// packed layout of the input and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE_TIME = 2'd0;
  localparam logic [1:0] REG_CLICK_WINDOW  = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LOW    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd35;
  localparam logic [15:0] WINDOW_RESET   = 16'd600;

  // Click event codes.
  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_SINGLE = 2'd1;
  localparam logic [1:0] EVT_DOUBLE = 2'd2;
  localparam logic [1:0] EVT_TRIPLE = 2'd3;

  // Color mode codes. The fourth code is never reached.
  localparam logic [1:0] COLOR_WARM   = 2'd0;
  localparam logic [1:0] COLOR_WHITE  = 2'd1;
  localparam logic [1:0] COLOR_DUAL   = 2'd2;
  localparam logic [1:0] COLOR_UNUSED = 2'd3;

  localparam logic [3:0] LEVEL_MAX = 4'd15;
  localparam logic [3:0] DUTY_OFF  = 4'd15;

  // One input beat, highest field first.
  typedef struct packed {
    logic              manual_locked;
    logic signed [3:0] encoder_steps;
    logic              button_level;
  } in_item_t;

  // One result beat, highest field first.
  typedef struct packed {
    logic [3:0] white_duty;
    logic [3:0] warm_duty;
    logic [3:0] level;
    logic [1:0] color_mode;
    logic       lamp_on;
    logic [1:0] click_event;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/lamp_click_and_dimmer_control.sv @@
// ----------------------------------------------------------------------------
// lamp_click_and_dimmer_control: debounced multi-click button and dimmer
// Debounces the button, groups releases into single, double and triple
// clicks, applies encoder steps to the brightness and drives two duties.
// ----------------------------------------------------------------------------
// An accepted input beat is held in the input register, its result beat in
// the result register. Throughput: one beat per cycle while the receiver
// takes results; the input side stalls only when the input register holds
// a tick and the result register holds a beat that is not taken in this cycle.
// Reset (rst, synchronous): both pipeline registers empty, configuration
// back to 35 ms debounce, 600 ms window, active-low button; lamp on, both
// channels, brightness 0, all counters cleared.
`default_nettype none

module lamp_click_and_dimmer_control
  import lcdc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // Input stream, one beat per millisecond tick.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: button_level [0], encoder_steps [4:1], manual_locked [5], zero [7:6]
  input  wire logic [7:0]  s_tdata,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: click_event [1:0], lamp_on [2], color_mode [4:3], level [8:5],
  //          warm_duty [12:9], white_duty [16:13], zero [23:17]
  output logic [23:0]      m_tdata
);

  // Compares run at the wider of the timer and the 16-bit registers.
  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Configuration registers.
  logic [15:0] debounce_time;
  logic [15:0] click_window;
  logic        press_is_low;

  // Input register stage.
  logic     in_valid;
  in_item_t in_item;

  // Result register stage.
  logic      out_valid;
  out_item_t out_item;

  // Block state.
  logic       prev_pressed;
  timer_t     since_change;
  logic [1:0] release_count;
  timer_t     since_first_release;
  timer_t     since_last_release;
  logic       on_flag;
  logic [1:0] mode_reg;
  logic [3:0] bright_reg;

  logic       prev_pressed_next;
  timer_t     since_change_next;
  logic [1:0] release_count_next;
  timer_t     since_first_release_next;
  timer_t     since_last_release_next;
  logic       on_flag_next;
  logic [1:0] mode_reg_next;
  logic [3:0] bright_reg_next;
  out_item_t  out_item_next;

  // The tick in the input register moves on when the result register is
  // empty or its beat is being taken in this cycle.
  logic advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_item};

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      click_window  <= WINDOW_RESET;
      press_is_low  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE_TIME: debounce_time <= cfg_wdata;
        REG_CLICK_WINDOW:  click_window  <= cfg_wdata;
        REG_ACTIVE_LOW:    press_is_low  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Saturating increment of an elapsed-time counter.
  function automatic timer_t tick_sat(input timer_t v);
    tick_sat = (&v) ? v : v + timer_t'(1);
  endfunction

  // One tick of work: timers, encoder, debounced edge, window timeout and
  // the duty outputs, all from the input register and the current state.
  always_comb begin
    logic              pressed;
    logic              locked;
    logic signed [5:0] sum;
    logic signed [5:0] low_limit;
    logic [3:0]        shown;
    logic [3:0]        inv;
    logic [1:0]        event_code;

    locked     = in_item.manual_locked;
    event_code = EVT_NONE;

    prev_pressed_next        = prev_pressed;
    release_count_next       = release_count;
    on_flag_next             = on_flag;
    mode_reg_next            = mode_reg;
    since_change_next        = tick_sat(since_change);
    since_first_release_next = tick_sat(since_first_release);
    since_last_release_next  = tick_sat(since_last_release);

    // Encoder: clamp against the on/off state from before this tick's clicks.
    sum       = $signed({2'b00, bright_reg}) +
                $signed({{2{in_item.encoder_steps[3]}}, in_item.encoder_steps});
    low_limit = $signed({5'd0, on_flag});
    bright_reg_next = bright_reg;
    if ((in_item.encoder_steps != 4'sd0) && !locked) begin
      if (sum < low_limit) begin
        bright_reg_next = {3'd0, on_flag};
      end else if (sum > $signed({2'b00, LEVEL_MAX})) begin
        bright_reg_next = LEVEL_MAX;
      end else begin
        bright_reg_next = sum[3:0];
      end
    end

    // Debounced edge; a release counts toward the click group.
    pressed = press_is_low ? !in_item.button_level : in_item.button_level;
    if ((pressed != prev_pressed) &&
        (CMP_W'(since_change_next) > CMP_W'(debounce_time))) begin
      since_change_next = '0;
      if (prev_pressed && !pressed) begin
        if (release_count == 2'd0) begin
          since_first_release_next = '0;
        end
        if (release_count != 2'd3) begin
          release_count_next = release_count + 2'd1;
        end
        since_last_release_next = '0;
        if ((release_count_next == 2'd3) &&
            (CMP_W'(since_first_release_next) <= CMP_W'(click_window))) begin
          event_code         = EVT_TRIPLE;
          release_count_next = 2'd0;
        end
      end
      prev_pressed_next = pressed;
    end

    // Window timeout closes the group; only single and double act on state.
    if ((release_count_next != 2'd0) &&
        (CMP_W'(since_last_release_next) > CMP_W'(click_window))) begin
      event_code         = release_count_next;
      release_count_next = 2'd0;
      if (!locked) begin
        if (event_code == EVT_DOUBLE) begin
          unique case (mode_reg)
            COLOR_WARM:   mode_reg_next = COLOR_WHITE;
            COLOR_WHITE:  mode_reg_next = COLOR_DUAL;
            COLOR_DUAL:   mode_reg_next = COLOR_WARM;
            COLOR_UNUSED: mode_reg_next = COLOR_WHITE;
            default:      mode_reg_next = COLOR_WARM;
          endcase
        end else if (event_code == EVT_SINGLE) begin
          on_flag_next = !on_flag;
        end
      end
    end

    // Duties from the final state; the shown level never drops below one.
    shown = (bright_reg_next == 4'd0) ? 4'd1 : bright_reg_next;
    inv   = DUTY_OFF - shown;
    out_item_next.warm_duty  = DUTY_OFF;
    out_item_next.white_duty = DUTY_OFF;
    if (on_flag_next) begin
      if (mode_reg_next == COLOR_WARM) begin
        out_item_next.warm_duty = inv;
      end else if (mode_reg_next == COLOR_WHITE) begin
        out_item_next.white_duty = inv;
      end else begin
        out_item_next.warm_duty  = inv;
        out_item_next.white_duty = inv;
      end
    end
    out_item_next.click_event = event_code;
    out_item_next.lamp_on     = on_flag_next;
    out_item_next.color_mode  = mode_reg_next;
    out_item_next.level       = bright_reg_next;
  end

  // Pipeline valid bits and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      out_valid           <= 1'b0;
      prev_pressed        <= 1'b0;
      since_change        <= '0;
      release_count       <= 2'd0;
      since_first_release <= '0;
      since_last_release  <= '0;
      on_flag             <= 1'b1;
      mode_reg            <= COLOR_DUAL;
      bright_reg          <= 4'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        prev_pressed        <= prev_pressed_next;
        since_change        <= since_change_next;
        release_count       <= release_count_next;
        since_first_release <= since_first_release_next;
        since_last_release  <= since_last_release_next;
        on_flag             <= on_flag_next;
        mode_reg            <= mode_reg_next;
        bright_reg          <= bright_reg_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[5:0]);
    end
    if (advance) begin
      out_item <= out_item_next;
    end
  end

  // The mode cycle never lands on the unused code.
  a_mode_valid: assert property (@(posedge clk) disable iff (rst)
    mode_reg != COLOR_UNUSED)
    else $error("color mode reached the unused code");

  // A held result with the lamp off shows both channels dark.
  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.lamp_on) |->
      (out_item.warm_duty == DUTY_OFF) && (out_item.white_duty == DUTY_OFF))
    else $error("lamp off but a duty is driven");

  // A locked tick leaves on/off, mode and brightness untouched.
  a_locked_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.manual_locked) |=>
      ($stable(on_flag) && $stable(mode_reg) && $stable(bright_reg)))
    else $error("locked tick changed lamp state");

  // The input side stalls only when a tick is held and cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without cause");

  // A tick that moves on always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("tick advanced without a result");

endmodule

`default_nettype wire
